[rtl/line_position_pid_steering_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the line position steering block
// Concurrent checks on clk with arst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_PID_STEERING_MACROS_SVH
`define LINE_POSITION_PID_STEERING_MACROS_SVH
`ifndef SYNTHESIS
`define LPPS_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define LPPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LPPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPPS_ASSERT(label, expr, msg)
`define LPPS_ASSERT_IMPL(label, ante, cons, msg)
`define LPPS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/lpps_pkg.sv]
// ----------------------------------------------------------------------------
// lpps_pkg
// Types, constants and a lookup function shared by the steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpps_pkg;

	localparam int BAR_W = 6;
	localparam int SENSOR_COUNT = 6;
	localparam int USED_BITS = (SENSOR_COUNT < BAR_W) ? SENSOR_COUNT : BAR_W;
	localparam int HISTORY_DEPTH_DEF = 6;

	localparam int POS_W = 11;
	localparam int GAIN_W = 20;
	localparam int TGT_W = 10;
	localparam int SPEED_W = 8;
	localparam int DUTY_W = 9;
	localparam int CFG_IDX_W = 3;

	localparam int WEIGHT_STEP = 100;
	localparam int WSUM_W = 12;
	localparam int CNT_W = 3;
	localparam int RECIP_W = 19;
	localparam int RECIP_SHIFT = 18;
	localparam int FRAC_BITS = 12;

	localparam logic signed [POS_W-1:0] EDGE_LOW = 11'sd100;
	localparam logic signed [POS_W-1:0] EDGE_HIGH = 11'sd500;
	localparam logic signed [POS_W-1:0] POS_MAX = 11'sd600;
	localparam logic signed [POS_W-1:0] POS_LOST = -11'sd1;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = 20'd1024;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 20'd34816;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 20'd4;
	localparam logic [TGT_W-1:0] TARGET_RST = 10'd350;
	localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 8'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P = 3'd0,
		REG_GAIN_D = 3'd1,
		REG_GAIN_I = 3'd2,
		REG_TARGET = 3'd3,
		REG_BASE_SPEED = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [BAR_W-1:0] front_bar;
		logic [BAR_W-1:0] back_bar;
		logic moving_forward;
	} sample_t;

	typedef struct packed {
		logic signed [POS_W-1:0] line_position;
		logic [DUTY_W-1:0] left_duty;
		logic [DUTY_W-1:0] right_duty;
		logic reverse_polarity;
	} steer_t;

	typedef struct packed {
		logic load;
		logic calc_pos;
		logic calc_div;
		logic calc_err;
		logic mul_p;
		logic mul_d;
		logic mul_i;
		logic finish;
	} cmd_t;

	// Rounded-up reciprocal of the set-bit count, scaled by two to the RECIP_SHIFT.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			3'd1: r = 19'd262144;
			3'd2: r = 19'd131072;
			3'd3: r = 19'd87382;
			3'd4: r = 19'd65536;
			3'd5: r = 19'd52429;
			3'd6: r = 19'd43691;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/lpps_ctrl.sv]
// ----------------------------------------------------------------------------
// lpps_ctrl
// Sequencer for one control tick and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_position_pid_steering_macros.svh"

module lpps_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	output logic steer_valid,
	input  logic steer_stall,
	output lpps_pkg::cmd_t cmd
);
	import lpps_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_POS  = 8'b0000_0010,
		ST_DIV  = 8'b0000_0100,
		ST_ERR  = 8'b0000_1000,
		ST_MP   = 8'b0001_0000,
		ST_MD   = 8'b0010_0000,
		ST_MI   = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic out_valid_q;
	logic accept;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept = sample_valid && !sample_stall;
	assign steer_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		cmd.calc_pos = (state_q == ST_POS);
		cmd.calc_div = (state_q == ST_DIV);
		cmd.calc_err = (state_q == ST_ERR);
		cmd.mul_p = (state_q == ST_MP);
		cmd.mul_d = (state_q == ST_MD);
		cmd.mul_i = (state_q == ST_MI);
		cmd.finish = (state_q == ST_FIN) && (!out_valid_q || !steer_stall);
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_n = ST_POS;
				end
			end
			ST_POS: state_n = ST_DIV;
			ST_DIV: state_n = ST_ERR;
			ST_ERR: state_n = ST_MP;
			ST_MP: state_n = ST_MD;
			ST_MD: state_n = ST_MI;
			ST_MI: state_n = ST_FIN;
			ST_FIN: begin
				if (cmd.finish) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!steer_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LPPS_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_POS, "Accepted item did not start")
	`LPPS_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid_q && state_q == ST_IDLE, "Result not shown")
	`LPPS_ASSERT_NEXT(a_fin_holds, state_q == ST_FIN && out_valid_q && steer_stall, state_q == ST_FIN, "Result slot overrun")

endmodule

`default_nettype wire

[rtl/lpps_datapath.sv]
// ----------------------------------------------------------------------------
// lpps_datapath
// Position, error history and shared gain multiplier for the steering block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_position_pid_steering_macros.svh"

module lpps_datapath #(
	parameter int HISTORY_DEPTH = lpps_pkg::HISTORY_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  lpps_pkg::cmd_t cmd,
	input  lpps_pkg::sample_t sample,
	input  logic cfg_we,
	input  logic [lpps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpps_pkg::GAIN_W-1:0] cfg_data,
	output lpps_pkg::steer_t steer
);
	import lpps_pkg::*;

	localparam int INTEG_W = POS_W + $clog2(HISTORY_DEPTH);
	localparam int OP_W = (INTEG_W > POS_W + 1) ? INTEG_W : POS_W + 1;
	localparam int PROD_W = OP_W + GAIN_W + 1;
	localparam int ACC_W = PROD_W + 2;

	logic [GAIN_W-1:0] gain_p_q;
	logic [GAIN_W-1:0] gain_d_q;
	logic [GAIN_W-1:0] gain_i_q;
	logic [TGT_W-1:0] target_q;
	logic [SPEED_W-1:0] base_q;

	logic [BAR_W-1:0] bar_q;
	logic fwd_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [POS_W-1:0] prev_pos_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [POS_W-1:0] err_q;
	logic signed [POS_W:0] deriv_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [INTEG_W-1:0] sum_q;
	logic signed [POS_W-1:0] hist_q [HISTORY_DEPTH];
	logic signed [ACC_W-1:0] acc_q;
	steer_t steer_q;

	logic [WSUM_W-1:0] wsum_n;
	logic [CNT_W-1:0] cnt_n;
	logic [WSUM_W+RECIP_W-1:0] div_prod;
	logic signed [POS_W-1:0] pos_n;
	logic signed [POS_W:0] err_full;
	logic signed [POS_W-1:0] err_n;
	logic signed [POS_W:0] deriv_n;
	logic signed [INTEG_W-1:0] sum_n;
	logic signed [OP_W-1:0] mul_a;
	logic [GAIN_W-1:0] mul_b;
	logic signed [PROD_W-1:0] product;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [ACC_W-1:0] corr_full;
	logic signed [ACC_W-1:0] lim_w;
	logic signed [ACC_W-1:0] corr_cl;
	logic signed [SPEED_W+1:0] corr_c;
	logic signed [SPEED_W+1:0] base_x;
	logic signed [SPEED_W+1:0] duty_x;
	steer_t steer_n;

	always_comb begin
		wsum_n = '0;
		cnt_n = '0;
		for (int i = 0; i < USED_BITS; i++) begin
			if (bar_q[i]) begin
				wsum_n = wsum_n + WSUM_W'((i + 1) * WEIGHT_STEP);
				cnt_n = cnt_n + CNT_W'(1);
			end
		end
	end

	assign div_prod = (WSUM_W+RECIP_W)'(wsum_q) * (WSUM_W+RECIP_W)'(recip_of(cnt_q));

	always_comb begin
		if (cnt_q == '0) begin
			if (prev_pos_q <= EDGE_LOW) begin
				pos_n = '0;
			end else if (prev_pos_q >= EDGE_HIGH) begin
				pos_n = POS_MAX;
			end else begin
				pos_n = POS_LOST;
			end
		end else begin
			pos_n = signed'({1'b0, div_prod[RECIP_SHIFT +: POS_W-1]});
		end
	end

	assign err_full = (POS_W+1)'(pos_q) - signed'({2'b00, target_q});
	assign err_n = err_full[POS_W-1:0];
	assign deriv_n = (POS_W+1)'(err_n) - (POS_W+1)'(hist_q[0]);
	assign sum_n = sum_q + INTEG_W'(err_n) - INTEG_W'(hist_q[HISTORY_DEPTH-1]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul_p) begin
			mul_a = OP_W'(err_q);
			mul_b = gain_p_q;
		end else if (cmd.mul_d) begin
			mul_a = OP_W'(deriv_q);
			mul_b = gain_d_q;
		end else if (cmd.mul_i) begin
			mul_a = OP_W'(integ_q);
			mul_b = gain_i_q;
		end
	end

	assign product = PROD_W'(mul_a) * PROD_W'(signed'({1'b0, mul_b}));

	// The sum of the products is scaled back with truncation toward zero.
	always_comb begin
		acc_rnd = acc_q;
		if (acc_q[ACC_W-1]) begin
			acc_rnd = acc_q + ACC_W'((1 << FRAC_BITS) - 1);
		end
		corr_full = acc_rnd >>> FRAC_BITS;
		lim_w = ACC_W'({1'b0, base_q});
		if (corr_full > lim_w) begin
			corr_cl = lim_w;
		end else if (corr_full < -lim_w) begin
			corr_cl = -lim_w;
		end else begin
			corr_cl = corr_full;
		end
		corr_c = corr_cl[SPEED_W+1:0];
		base_x = signed'({2'b00, base_q});
		steer_n.line_position = pos_q;
		steer_n.reverse_polarity = !fwd_q;
		if (corr_c < 0) begin
			duty_x = base_x + corr_c;
			steer_n.left_duty = base_x[DUTY_W-1:0];
			steer_n.right_duty = duty_x[DUTY_W-1:0];
		end else begin
			duty_x = base_x - corr_c;
			steer_n.left_duty = duty_x[DUTY_W-1:0];
			steer_n.right_duty = base_x[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_d_q <= GAIN_D_RST;
			gain_i_q <= GAIN_I_RST;
			target_q <= TARGET_RST;
			base_q <= BASE_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_D: gain_d_q <= cfg_data;
				REG_GAIN_I: gain_i_q <= cfg_data;
				REG_TARGET: target_q <= cfg_data[TGT_W-1:0];
				REG_BASE_SPEED: base_q <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= '0;
			sum_q <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cmd.calc_div) begin
				prev_pos_q <= pos_n;
			end
			if (cmd.calc_err) begin
				sum_q <= sum_n;
				hist_q[0] <= err_n;
				for (int i = 1; i < HISTORY_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bar_q <= sample.moving_forward ? sample.front_bar : sample.back_bar;
			fwd_q <= sample.moving_forward;
		end
		if (cmd.calc_pos) begin
			wsum_q <= wsum_n;
			cnt_q <= cnt_n;
		end
		if (cmd.calc_div) begin
			pos_q <= pos_n;
		end
		if (cmd.calc_err) begin
			err_q <= err_n;
			deriv_q <= deriv_n;
			integ_q <= sum_q;
		end
		if (cmd.mul_p) begin
			acc_q <= ACC_W'(product);
		end else if (cmd.mul_d || cmd.mul_i) begin
			acc_q <= acc_q + ACC_W'(product);
		end
		if (cmd.finish) begin
			steer_q <= steer_n;
		end
	end

	assign steer = steer_q;

	`LPPS_ASSERT_IMPL(a_duty_bound, cmd.finish,
		steer_n.left_duty <= {1'b0, base_q} && steer_n.right_duty <= {1'b0, base_q},
		"Duty above base speed")
	`LPPS_ASSERT_IMPL(a_one_side_base, cmd.finish,
		steer_n.left_duty == {1'b0, base_q} || steer_n.right_duty == {1'b0, base_q},
		"Both duties reduced")

endmodule

`default_nettype wire

[rtl/line_position_pid_steering.sv]
// ----------------------------------------------------------------------------
// line_position_pid_steering
// One result per sample: the line position from the selected sensor bar and
// left and right motor duties from a PID correction clamped to the base
// speed. An item passes through capturing the bar, the weighted sum and
// count, the reciprocal divide, the error and history shift, the P, D and
// I products on the single shared multiplier, and the load of the output
// register, which waits while an earlier result is still stalled. The
// result then waits in that register, and a new sample is taken while it
// waits. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_pid_steering #(
	parameter int HISTORY_DEPTH = lpps_pkg::HISTORY_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  lpps_pkg::sample_t sample,
	output logic steer_valid,
	input  logic steer_stall,
	output lpps_pkg::steer_t steer,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lpps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpps_pkg::GAIN_W-1:0] cfg_data
);
	import lpps_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	lpps_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.steer_valid(steer_valid),
		.steer_stall(steer_stall),
		.cmd(cmd)
	);

	lpps_datapath #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sample(sample),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.steer(steer)
	);

endmodule

`default_nettype wire
